### rtl/blte_pkg.sv
// Shared types, codes and widths for the bounded list table engine.
package blte_pkg;

    localparam int CAPACITY_DEF = 128;
    localparam int WORD_W       = 32;
    localparam int SLOT_W       = 7;
    localparam int FILL_W       = 8;
    localparam int TYPE_W       = 3;
    localparam int STATUS_W     = 2;

    localparam logic [TYPE_W-1:0] REQ_FIND   = 3'd0;
    localparam logic [TYPE_W-1:0] REQ_MODIFY = 3'd1;
    localparam logic [TYPE_W-1:0] REQ_APPEND = 3'd2;
    localparam logic [TYPE_W-1:0] REQ_CLEAR  = 3'd3;
    localparam logic [TYPE_W-1:0] REQ_REMOVE = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_W-1:0]        found_slot;
        logic signed [WORD_W-1:0] old_word;
        logic [FILL_W-1:0]        fill;
    } blte_rsp_t;

endpackage

### rtl/bounded_list_table_engine_core.sv
// Top level of the bounded list table engine: sequencer, entry RAM, result register.
// One request at a time. Append, clear and invalid requests go straight from
// idle to the result state, and modify passes through a write state; find
// walks from slot 0 until a match or the end, and remove walks from slot + 1
// to the end; both walk the list through the single read port of the entry RAM,
// one entry per cycle. A finished result sits in an output register, so a new
// request can be taken while the previous result waits. The entry RAM needs no
// clearing after reset; only the fill count and the sequencer control are reset.
module bounded_list_table_engine_core #(
    parameter int CAPACITY = blte_pkg::CAPACITY_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  logic [blte_pkg::TYPE_W-1:0]        req_type,
    input  logic [blte_pkg::SLOT_W-1:0]        slot,
    input  logic signed [blte_pkg::WORD_W-1:0] word,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output logic [blte_pkg::STATUS_W-1:0]      status,
    output logic [blte_pkg::SLOT_W-1:0]        found_slot,
    output logic signed [blte_pkg::WORD_W-1:0] old_word,
    output logic [blte_pkg::FILL_W-1:0]        fill
);

    import blte_pkg::*;

    localparam int AW = $clog2(CAPACITY);

    logic              res_valid;
    logic              res_ready;
    blte_rsp_t         res;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic      rsp_valid_reg;
    blte_rsp_t rsp_reg;

    blte_seq #(
        .CAPACITY (CAPACITY)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_type  (req_type),
        .slot      (slot),
        .word      (word),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    blte_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid  = rsp_valid_reg;
    assign status     = rsp_reg.status;
    assign found_slot = rsp_reg.found_slot;
    assign old_word   = rsp_reg.old_word;
    assign fill       = rsp_reg.fill;

endmodule

### rtl/blte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module blte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/blte_seq.sv
// Request sequencer: decodes a request and walks the list through one RAM port.
module blte_seq #(
    parameter int CAPACITY = blte_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  logic [blte_pkg::TYPE_W-1:0]          req_type,
    input  logic [blte_pkg::SLOT_W-1:0]          slot,
    input  logic signed [blte_pkg::WORD_W-1:0]   word,
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output blte_pkg::blte_rsp_t                  res,
    output logic                                 ram_we,
    output logic [$clog2(CAPACITY)-1:0]          ram_waddr,
    output logic [blte_pkg::WORD_W-1:0]          ram_wdata,
    output logic [$clog2(CAPACITY)-1:0]          ram_raddr,
    input  logic [blte_pkg::WORD_W-1:0]          ram_rdata
);

    import blte_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > SLOT_W) ? CW : SLOT_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_WALK   = 2'd1;
    localparam logic [1:0] S_MOD_WR = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    logic [1:0]               state_reg, state_next;
    logic [TYPE_W-1:0]        op_reg, op_next;
    logic [CW-1:0]            ptr_reg, ptr_next;
    logic                     pend_reg, pend_next;
    logic [AW-1:0]            pidx_reg, pidx_next;
    logic [AW-1:0]            addr_reg, addr_next;
    logic signed [WORD_W-1:0] key_reg, key_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [STATUS_W-1:0]      status_reg, status_next;
    logic [SLOT_W-1:0]        hit_reg, hit_next;
    logic signed [WORD_W-1:0] old_reg, old_next;

    logic          slot_ok;
    logic          issue;
    logic [LW-1:0] slot_l;

    assign slot_l  = LW'(slot);
    assign slot_ok = slot_l < LW'(count_reg);
    assign issue   = ptr_reg < count_reg;

    always_comb
    begin
        state_next  = state_reg;
        op_next     = op_reg;
        ptr_next    = ptr_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        addr_next   = addr_reg;
        key_next    = key_reg;
        count_next  = count_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        old_next    = old_reg;
        ram_we      = 1'b0;
        ram_waddr   = addr_reg;
        ram_wdata   = key_reg;
        ram_raddr   = ptr_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE:
            begin
                ram_raddr = AW'(slot);
                if (req_valid)
                begin
                    op_next     = req_type;
                    key_next    = word;
                    addr_next   = AW'(slot);
                    status_next = ST_OK;
                    hit_next    = '0;
                    old_next    = '0;
                    pend_next   = 1'b0;
                    state_next  = S_DONE;
                    unique case (req_type)
                        REQ_FIND:
                        begin
                            ptr_next   = '0;
                            state_next = S_WALK;
                        end
                        REQ_MODIFY:
                        begin
                            if (slot_ok)
                                state_next = S_MOD_WR;
                            else
                                status_next = ST_BAD_INDEX;
                        end
                        REQ_APPEND:
                        begin
                            if (count_reg < CW'(CAPACITY))
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = count_reg[AW-1:0];
                                ram_wdata  = word;
                                count_next = count_reg + 1'b1;
                            end
                            else
                            begin
                                status_next = ST_FULL;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            if (slot_ok)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(slot);
                                ram_wdata = '0;
                            end
                            else
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                        end
                        REQ_REMOVE:
                        begin
                            if (slot_ok)
                            begin
                                ptr_next   = CW'(slot_l + 1'b1);
                                state_next = S_WALK;
                            end
                            else
                            begin
                                status_next = ST_BAD_INDEX;
                            end
                        end
                        default:
                        begin
                            status_next = ST_BAD_INDEX;
                        end
                    endcase
                end
            end
            S_WALK:
            begin
                pend_next = issue;
                pidx_next = ptr_reg[AW-1:0];
                if (issue)
                    ptr_next = ptr_reg + 1'b1;
                if (op_reg == REQ_FIND)
                begin
                    if (pend_reg && (ram_rdata == key_reg))
                    begin
                        hit_next   = SLOT_W'(pidx_reg);
                        pend_next  = 1'b0;
                        state_next = S_DONE;
                    end
                    else if (!issue)
                    begin
                        status_next = ST_NOT_FOUND;
                        pend_next   = 1'b0;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    // shift down: entry read last cycle lands one slot lower
                    ram_we    = pend_reg;
                    ram_waddr = pidx_reg - 1'b1;
                    ram_wdata = ram_rdata;
                    if (!issue)
                    begin
                        count_next = count_reg - 1'b1;
                        state_next = S_DONE;
                    end
                end
            end
            S_MOD_WR:
            begin
                old_next   = ram_rdata;
                ram_we     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        ptr_reg    <= ptr_next;
        pidx_reg   <= pidx_next;
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        hit_reg    <= hit_next;
        old_reg    <= old_next;
    end

    assign req_ready      = (state_reg == S_IDLE);
    assign res_valid      = (state_reg == S_DONE);
    assign res.status     = status_reg;
    assign res.found_slot = hit_reg;
    assign res.old_word   = old_reg;
    assign res.fill       = FILL_W'(count_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("fill count above capacity");

    a_walk_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (ptr_reg <= count_reg))
        else $error("walk pointer past fill count");

    a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && op_reg == REQ_FIND) |-> !ram_we)
        else $error("find wrote the table");

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_ready) |=> (state_reg == S_IDLE))
        else $error("result handoff did not return to idle");

    a_remove_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK && op_reg == REQ_REMOVE && !issue)
        |=> (count_reg == $past(count_reg) - 1'b1))
        else $error("remove did not shrink the list");

endmodule
